// ----- design/mrgp_pkg.sv -----
// Package for the mouse ray ground plane pick block.
// Holds widths, pipeline depths, register defaults, status codes and the
// divider step functions. No dependencies.
package mrgp_pkg;

   // screen size and mouse fields
   localparam int SCR_W      = 13;
   localparam int FRAC_Q16   = 16;
   localparam int FOCAL_W    = 19;

   // ndc and aspect dividers: (value << 16) / screen size
   localparam int NDC_NUM_W  = SCR_W + FRAC_Q16;
   localparam int NDC_ACC_W  = SCR_W + NDC_NUM_W;
   localparam int DIV_STEPS  = NDC_NUM_W;

   // reduced direction and hit divider
   localparam int RED_W      = 31;
   localparam int HIT_Q_W    = 33;
   localparam int HIT_ACC_W  = RED_W + HIT_Q_W;
   localparam int HIT_STEPS  = HIT_Q_W;

   // stages between the dividers
   localparam int MID_STAGES = 8;
   localparam int PIPE_DEPTH = 1 + DIV_STEPS + MID_STAGES + HIT_STEPS;
   localparam int E8_STAGE   = DIV_STEPS + MID_STAGES;

   localparam logic [16:0] HALF_Q16 = 17'd32768;

   // 1e12 = 5^12 * 2^12
   localparam logic [27:0] EPS_ODD    = 28'd244140625;
   localparam int          EPS_SHIFT  = 12;
   localparam int          SMALL_AY_W = 13;

   localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
   localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

   // register defaults
   localparam logic [SCR_W-1:0]   WIDTH_RESET  = 13'd1920;
   localparam logic [SCR_W-1:0]   HEIGHT_RESET = 13'd1080;
   localparam logic [FOCAL_W-1:0] FOCAL_RESET  = 19'd55706;

   // register indexes
   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_FOCAL_LENGTH  = 2'd2;

   typedef enum logic [1:0] {
      STATUS_HIT      = 2'd0,
      STATUS_PARALLEL = 2'd1,
      STATUS_BEHIND   = 2'd2
   } pick_status_type;

   // one restoring step: {rem, num/quotient}
   function automatic logic [NDC_ACC_W-1:0] ndc_div_step(input logic [NDC_ACC_W-1:0] acc,
                                                         input logic [SCR_W-1:0] d);
      logic [SCR_W:0] t;
      logic           q;
      t = acc[NDC_ACC_W-1 -: SCR_W+1];
      q = (t >= {1'b0, d});
      if (q) begin
         t = t - {1'b0, d};
      end
      return {t[SCR_W-1:0], acc[NDC_NUM_W-2:0], q};
   endfunction

   function automatic logic [HIT_ACC_W-1:0] hit_div_step(input logic [HIT_ACC_W-1:0] acc,
                                                         input logic [RED_W-1:0] d);
      logic [RED_W:0] t;
      logic           q;
      t = acc[HIT_ACC_W-1 -: RED_W+1];
      q = (t >= {1'b0, d});
      if (q) begin
         t = t - {1'b0, d};
      end
      return {t[RED_W-1:0], acc[HIT_Q_W-2:0], q};
   endfunction

   // cam - signed quotient, saturated to int32
   function automatic logic [31:0] hit_coord(input logic signed [31:0] c,
                                             input logic [HIT_Q_W-1:0] q,
                                             input logic neg, input logic ovf);
      logic signed [HIT_Q_W:0] sq;
      logic signed [34:0]      diff;
      logic [31:0]             r;
      sq   = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
      diff = 35'(c) - 35'(sq);
      if (ovf) begin
         r = neg ? SAT_MAX[31:0] : SAT_MIN[31:0];
      end else if (diff > SAT_MAX) begin
         r = SAT_MAX[31:0];
      end else if (diff < SAT_MIN) begin
         r = SAT_MIN[31:0];
      end else begin
         r = diff[31:0];
      end
      return r;
   endfunction

endpackage

// ----- design/mouse_ray_ground_plane_pick.sv -----
// Accepts one request per cycle while req_stall is low.
// Depth is set by two restoring divider chains, one quotient bit per stage:
// 29 stages for ndc and aspect, 33 stages for the ground hit.
// The whole pipeline holds while a result waits under rsp_stall.
// Reset (synchronous) clears all valid bits and loads the register defaults.
// Depends on mrgp_pkg.
module mouse_ray_ground_plane_pick (
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_wen,
   input  logic [1:0]          csr_index,
   input  logic [18:0]         csr_wdata,
   // requests
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [12:0]         req_mouse_x,
   input  logic [12:0]         req_mouse_y,
   input  logic signed [31:0]  req_cam_pos_x,
   input  logic signed [31:0]  req_cam_pos_y,
   input  logic signed [31:0]  req_cam_pos_z,
   input  logic signed [15:0]  req_fwd_x,
   input  logic signed [15:0]  req_fwd_y,
   input  logic signed [15:0]  req_fwd_z,
   input  logic signed [15:0]  req_up_x,
   input  logic signed [15:0]  req_up_y,
   input  logic signed [15:0]  req_up_z,
   // results
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_hit_x,
   output logic signed [31:0]  rsp_hit_y,
   output logic signed [31:0]  rsp_hit_z,
   output logic [1:0]          rsp_pick_status
);

   typedef struct packed {
      logic signed [31:0] cx, cy, cz;
      logic signed [15:0] fx, fy, fz, ux, uy, uz;
      logic [mrgp_pkg::FOCAL_W-1:0] focal;
   } cam_type;

   typedef struct packed {
      logic [mrgp_pkg::NDC_ACC_W-1:0] accx, accy, acca;
      logic [mrgp_pkg::SCR_W-1:0]     w, h;
      cam_type                        cam;
   } dv_type;

   typedef struct packed {
      logic signed [16:0] ndcx, ndcy;
      logic [mrgp_pkg::NDC_NUM_W-1:0] aspect;
      logic signed [32:0] qx, qy, qz;
      logic signed [35:0] fpx, fpy, fpz;
      logic signed [15:0] ux, uy, uz;
      logic signed [31:0] cx, cy, cz;
   } e1_type;

   typedef struct packed {
      logic signed [46:0] wsp;
      logic signed [32:0] qx, qy, qz;
      logic signed [35:0] fpx, fpy, fpz;
      logic signed [32:0] upx, upy, upz;
      logic signed [31:0] cx, cy, cz;
   } e2_type;

   typedef struct packed {
      logic signed [63:0] qwx, qwy, qwz;
      logic signed [35:0] fpx, fpy, fpz;
      logic signed [32:0] upx, upy, upz;
      logic signed [31:0] cx, cy, cz;
   } e3_type;

   typedef struct packed {
      logic signed [47:0] dx, dy, dz;
      logic signed [31:0] cx, cy, cz;
   } e4_type;

   typedef struct packed {
      logic [46:0] mx, my, mz;
      logic        nx, ny, nz;
      logic [4:0]  k;
      logic signed [31:0] cx, cy, cz;
   } e5_type;

   typedef struct packed {
      logic [mrgp_pkg::RED_W-1:0] rx, ry, rz;
      logic        nx, ny, nz;
      logic [31:0] cyabs;
      logic        cy_neg, cy_zero;
      logic signed [31:0] cx, cz;
   } e6_type;

   typedef struct packed {
      logic [61:0] sqx, sqy, sqz;
      logic [62:0] numx, numz;
      logic [mrgp_pkg::RED_W-1:0] ry;
      logic        sgnx, sgnz, ry_neg, cy_neg, cy_zero;
      logic signed [31:0] cx, cz;
   } e7_type;

   typedef struct packed {
      logic [63:0] sum;
      logic [53:0] t;
      logic        big, ovfx, ovfz;
      logic [mrgp_pkg::HIT_ACC_W-1:0] accx, accz;
      logic [mrgp_pkg::RED_W-1:0]     d;
      logic        sgnx, sgnz, ry_neg, cy_neg, cy_zero;
      logic signed [31:0] cx, cz;
   } e8_type;

   typedef struct packed {
      logic [mrgp_pkg::HIT_ACC_W-1:0] accx, accz;
      logic [mrgp_pkg::RED_W-1:0]     d;
      logic        sgnx, sgnz, ovfx, ovfz;
      mrgp_pkg::pick_status_type      status;
      logic signed [31:0] cx, cz;
   } hc_type;

   // configuration registers
   logic [mrgp_pkg::SCR_W-1:0]   csr_width_ff, csr_height_ff;
   logic [mrgp_pkg::FOCAL_W-1:0] csr_focal_ff;
   logic [mrgp_pkg::SCR_W-1:0]   w_eff, h_eff, mx_c, my_c;

   // pipeline control
   logic                            adv;
   logic [mrgp_pkg::PIPE_DEPTH-1:0] vld_ff, vld_in;
   logic                            rsp_valid_ff;

   // pipeline payload
   dv_type dv_ff [0:mrgp_pkg::DIV_STEPS];
   dv_type dv_in [0:mrgp_pkg::DIV_STEPS];
   e1_type e1_ff, e1_in;
   e2_type e2_ff, e2_in;
   e3_type e3_ff, e3_in;
   e4_type e4_ff, e4_in;
   e5_type e5_ff, e5_in;
   e6_type e6_ff, e6_in;
   e7_type e7_ff, e7_in;
   e8_type e8_ff, e8_in;
   hc_type hc_ff [0:mrgp_pkg::HIT_STEPS-1];
   hc_type hc_in [0:mrgp_pkg::HIT_STEPS-1];

   logic [31:0]                   rsp_hit_x_ff, rsp_hit_z_ff;
   logic [31:0]                   rsp_hit_x_in, rsp_hit_z_in;
   mrgp_pkg::pick_status_type     rsp_status_ff;

   // whole pipeline moves unless a result is held
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign vld_in    = {vld_ff[mrgp_pkg::PIPE_DEPTH-2:0], req_valid};

   // zero screen size counts as one; clamp mouse to screen
   assign w_eff = (csr_width_ff == '0) ? 13'd1 : csr_width_ff;
   assign h_eff = (csr_height_ff == '0) ? 13'd1 : csr_height_ff;
   assign mx_c  = (req_mouse_x > w_eff) ? w_eff : req_mouse_x;
   assign my_c  = (req_mouse_y > h_eff) ? h_eff : req_mouse_y;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_width_ff  <= mrgp_pkg::WIDTH_RESET;
         csr_height_ff <= mrgp_pkg::HEIGHT_RESET;
         csr_focal_ff  <= mrgp_pkg::FOCAL_RESET;
         vld_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               mrgp_pkg::CSR_SCREEN_WIDTH: begin
                  csr_width_ff <= csr_wdata[mrgp_pkg::SCR_W-1:0];
               end
               mrgp_pkg::CSR_SCREEN_HEIGHT: begin
                  csr_height_ff <= csr_wdata[mrgp_pkg::SCR_W-1:0];
               end
               mrgp_pkg::CSR_FOCAL_LENGTH: begin
                  csr_focal_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (adv) begin
            vld_ff       <= vld_in;
            rsp_valid_ff <= vld_ff[mrgp_pkg::PIPE_DEPTH-1];
         end
      end
   end

   // ndc x, ndc y and aspect dividers
   always_comb begin
      dv_in[0].accx = {{mrgp_pkg::SCR_W{1'b0}}, mx_c, {mrgp_pkg::FRAC_Q16{1'b0}}};
      dv_in[0].accy = {{mrgp_pkg::SCR_W{1'b0}}, my_c, {mrgp_pkg::FRAC_Q16{1'b0}}};
      dv_in[0].acca = {{mrgp_pkg::SCR_W{1'b0}}, w_eff, {mrgp_pkg::FRAC_Q16{1'b0}}};
      dv_in[0].w    = w_eff;
      dv_in[0].h    = h_eff;
      dv_in[0].cam  = '{cx: req_cam_pos_x, cy: req_cam_pos_y, cz: req_cam_pos_z,
                        fx: req_fwd_x, fy: req_fwd_y, fz: req_fwd_z,
                        ux: req_up_x, uy: req_up_y, uz: req_up_z,
                        focal: csr_focal_ff};
      for (int i = 1; i <= mrgp_pkg::DIV_STEPS; i++) begin
         dv_in[i]      = dv_ff[i-1];
         dv_in[i].accx = mrgp_pkg::ndc_div_step(dv_ff[i-1].accx, dv_ff[i-1].w);
         dv_in[i].accy = mrgp_pkg::ndc_div_step(dv_ff[i-1].accy, dv_ff[i-1].h);
         dv_in[i].acca = mrgp_pkg::ndc_div_step(dv_ff[i-1].acca, dv_ff[i-1].h);
      end
   end

   // E1: ndc offsets, cross product, forward * focal
   always_comb begin
      dv_type s;
      s = dv_ff[mrgp_pkg::DIV_STEPS];
      e1_in.ndcx   = $signed(s.accx[16:0] - mrgp_pkg::HALF_Q16);
      e1_in.ndcy   = $signed(s.accy[16:0] - mrgp_pkg::HALF_Q16);
      e1_in.aspect = s.acca[mrgp_pkg::NDC_NUM_W-1:0];
      e1_in.qx  = 33'(s.cam.fy * s.cam.uz) - 33'(s.cam.fz * s.cam.uy);
      e1_in.qy  = 33'(s.cam.fz * s.cam.ux) - 33'(s.cam.fx * s.cam.uz);
      e1_in.qz  = 33'(s.cam.fx * s.cam.uy) - 33'(s.cam.fy * s.cam.ux);
      e1_in.fpx = s.cam.fx * $signed({1'b0, s.cam.focal});
      e1_in.fpy = s.cam.fy * $signed({1'b0, s.cam.focal});
      e1_in.fpz = s.cam.fz * $signed({1'b0, s.cam.focal});
      e1_in.ux  = s.cam.ux;
      e1_in.uy  = s.cam.uy;
      e1_in.uz  = s.cam.uz;
      e1_in.cx  = s.cam.cx;
      e1_in.cy  = s.cam.cy;
      e1_in.cz  = s.cam.cz;
   end

   // E2: aspect * ndc x, up * ndc y
   always_comb begin
      e2_in.wsp = $signed({1'b0, e1_ff.aspect}) * e1_ff.ndcx;
      e2_in.qx  = e1_ff.qx;
      e2_in.qy  = e1_ff.qy;
      e2_in.qz  = e1_ff.qz;
      e2_in.fpx = e1_ff.fpx;
      e2_in.fpy = e1_ff.fpy;
      e2_in.fpz = e1_ff.fpz;
      e2_in.upx = e1_ff.ux * e1_ff.ndcy;
      e2_in.upy = e1_ff.uy * e1_ff.ndcy;
      e2_in.upz = e1_ff.uz * e1_ff.ndcy;
      e2_in.cx  = e1_ff.cx;
      e2_in.cy  = e1_ff.cy;
      e2_in.cz  = e1_ff.cz;
   end

   // E3: cross * width scale (floor shift by 16 is the bit select)
   always_comb begin
      logic signed [30:0] ws;
      ws = $signed(e2_ff.wsp[46:16]);
      e3_in.qwx = e2_ff.qx * ws;
      e3_in.qwy = e2_ff.qy * ws;
      e3_in.qwz = e2_ff.qz * ws;
      e3_in.fpx = e2_ff.fpx;
      e3_in.fpy = e2_ff.fpy;
      e3_in.fpz = e2_ff.fpz;
      e3_in.upx = e2_ff.upx;
      e3_in.upy = e2_ff.upy;
      e3_in.upz = e2_ff.upz;
      e3_in.cx  = e2_ff.cx;
      e3_in.cy  = e2_ff.cy;
      e3_in.cz  = e2_ff.cz;
   end

   // E4: ray direction, 31 fraction bits
   always_comb begin
      e4_in.dx = 48'(e3_ff.fpx) + $signed(e3_ff.qwx[62:15]) - 48'(e3_ff.upx);
      e4_in.dy = 48'(e3_ff.fpy) + $signed(e3_ff.qwy[62:15]) - 48'(e3_ff.upy);
      e4_in.dz = 48'(e3_ff.fpz) + $signed(e3_ff.qwz[62:15]) - 48'(e3_ff.upz);
      e4_in.cx = e3_ff.cx;
      e4_in.cy = e3_ff.cy;
      e4_in.cz = e3_ff.cz;
   end

   // E5: magnitudes and block shift from the leading one
   always_comb begin
      logic [46:0] ord;
      e5_in.nx = e4_ff.dx[47];
      e5_in.ny = e4_ff.dy[47];
      e5_in.nz = e4_ff.dz[47];
      e5_in.mx = e4_ff.dx[47] ? 47'(-e4_ff.dx) : 47'(e4_ff.dx);
      e5_in.my = e4_ff.dy[47] ? 47'(-e4_ff.dy) : 47'(e4_ff.dy);
      e5_in.mz = e4_ff.dz[47] ? 47'(-e4_ff.dz) : 47'(e4_ff.dz);
      ord      = e5_in.mx | e5_in.my | e5_in.mz;
      e5_in.k  = '0;
      for (int i = mrgp_pkg::RED_W; i < 47; i++) begin
         if (ord[i]) begin
            e5_in.k = 5'(i - (mrgp_pkg::RED_W - 1));
         end
      end
      e5_in.cx = e4_ff.cx;
      e5_in.cy = e4_ff.cy;
      e5_in.cz = e4_ff.cz;
   end

   // E6: reduced vector, camera height magnitude
   always_comb begin
      e6_in.rx      = mrgp_pkg::RED_W'(e5_ff.mx >> e5_ff.k);
      e6_in.ry      = mrgp_pkg::RED_W'(e5_ff.my >> e5_ff.k);
      e6_in.rz      = mrgp_pkg::RED_W'(e5_ff.mz >> e5_ff.k);
      e6_in.nx      = e5_ff.nx;
      e6_in.ny      = e5_ff.ny;
      e6_in.nz      = e5_ff.nz;
      e6_in.cyabs   = e5_ff.cy[31] ? 32'(-e5_ff.cy) : 32'(e5_ff.cy);
      e6_in.cy_neg  = e5_ff.cy[31];
      e6_in.cy_zero = (e5_ff.cy == '0);
      e6_in.cx      = e5_ff.cx;
      e6_in.cz      = e5_ff.cz;
   end

   // E7: squares and hit numerators
   always_comb begin
      e7_in.sqx     = e6_ff.rx * e6_ff.rx;
      e7_in.sqy     = e6_ff.ry * e6_ff.ry;
      e7_in.sqz     = e6_ff.rz * e6_ff.rz;
      e7_in.numx    = e6_ff.cyabs * e6_ff.rx;
      e7_in.numz    = e6_ff.cyabs * e6_ff.rz;
      e7_in.ry      = e6_ff.ry;
      e7_in.sgnx    = e6_ff.cy_neg ^ e6_ff.nx ^ e6_ff.ny;
      e7_in.sgnz    = e6_ff.cy_neg ^ e6_ff.nz ^ e6_ff.ny;
      e7_in.ry_neg  = e6_ff.ny;
      e7_in.cy_neg  = e6_ff.cy_neg;
      e7_in.cy_zero = e6_ff.cy_zero;
      e7_in.cx      = e6_ff.cx;
      e7_in.cz      = e6_ff.cz;
   end

   // E8: length sum, scaled y square, quotient overflow
   always_comb begin
      e8_in.sum  = 64'(e7_ff.sqx) + 64'(e7_ff.sqy) + 64'(e7_ff.sqz);
      e8_in.t    = e7_ff.sqy[2*mrgp_pkg::SMALL_AY_W-1:0] * mrgp_pkg::EPS_ODD;
      e8_in.big  = |e7_ff.sqy[61:2*mrgp_pkg::SMALL_AY_W];
      e8_in.ovfx = {1'b0, e7_ff.numx} >= {e7_ff.ry, {mrgp_pkg::HIT_Q_W{1'b0}}};
      e8_in.ovfz = {1'b0, e7_ff.numz} >= {e7_ff.ry, {mrgp_pkg::HIT_Q_W{1'b0}}};
      e8_in.accx = {1'b0, e7_ff.numx};
      e8_in.accz = {1'b0, e7_ff.numz};
      e8_in.d       = e7_ff.ry;
      e8_in.sgnx    = e7_ff.sgnx;
      e8_in.sgnz    = e7_ff.sgnz;
      e8_in.ry_neg  = e7_ff.ry_neg;
      e8_in.cy_neg  = e7_ff.cy_neg;
      e8_in.cy_zero = e7_ff.cy_zero;
      e8_in.cx      = e7_ff.cx;
      e8_in.cz      = e7_ff.cz;
   end

   // hit divider chain; status decided on entry
   always_comb begin
      logic par, behind;
      par    = !e8_ff.big &&
               ({e8_ff.t, {mrgp_pkg::EPS_SHIFT{1'b0}}} <= {2'b00, e8_ff.sum});
      behind = !e8_ff.cy_zero && (e8_ff.cy_neg == e8_ff.ry_neg);
      hc_in[0].accx = mrgp_pkg::hit_div_step(e8_ff.accx, e8_ff.d);
      hc_in[0].accz = mrgp_pkg::hit_div_step(e8_ff.accz, e8_ff.d);
      hc_in[0].d    = e8_ff.d;
      hc_in[0].sgnx = e8_ff.sgnx;
      hc_in[0].sgnz = e8_ff.sgnz;
      hc_in[0].ovfx = e8_ff.ovfx;
      hc_in[0].ovfz = e8_ff.ovfz;
      hc_in[0].status = par ? mrgp_pkg::STATUS_PARALLEL :
                        behind ? mrgp_pkg::STATUS_BEHIND : mrgp_pkg::STATUS_HIT;
      hc_in[0].cx   = e8_ff.cx;
      hc_in[0].cz   = e8_ff.cz;
      for (int i = 1; i < mrgp_pkg::HIT_STEPS; i++) begin
         hc_in[i]      = hc_ff[i-1];
         hc_in[i].accx = mrgp_pkg::hit_div_step(hc_ff[i-1].accx, hc_ff[i-1].d);
         hc_in[i].accz = mrgp_pkg::hit_div_step(hc_ff[i-1].accz, hc_ff[i-1].d);
      end
   end

   // final hit point, zero when there is no hit
   always_comb begin
      hc_type s;
      s = hc_ff[mrgp_pkg::HIT_STEPS-1];
      if (s.status == mrgp_pkg::STATUS_HIT) begin
         rsp_hit_x_in = mrgp_pkg::hit_coord(s.cx, s.accx[mrgp_pkg::HIT_Q_W-1:0],
                                            s.sgnx, s.ovfx);
         rsp_hit_z_in = mrgp_pkg::hit_coord(s.cz, s.accz[mrgp_pkg::HIT_Q_W-1:0],
                                            s.sgnz, s.ovfz);
      end else begin
         rsp_hit_x_in = '0;
         rsp_hit_z_in = '0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff         <= dv_in;
         e1_ff         <= e1_in;
         e2_ff         <= e2_in;
         e3_ff         <= e3_in;
         e4_ff         <= e4_in;
         e5_ff         <= e5_in;
         e6_ff         <= e6_in;
         e7_ff         <= e7_in;
         e8_ff         <= e8_in;
         hc_ff         <= hc_in;
         rsp_hit_x_ff  <= rsp_hit_x_in;
         rsp_hit_z_ff  <= rsp_hit_z_in;
         rsp_status_ff <= hc_ff[mrgp_pkg::HIT_STEPS-1].status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit_x       = $signed(rsp_hit_x_ff);
   assign rsp_hit_y       = 32'sd0;
   assign rsp_hit_z       = $signed(rsp_hit_z_ff);
   assign rsp_pick_status = rsp_status_ff;

`ifndef SYNTHESIS
   // no hit means a zero hit point
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != mrgp_pkg::STATUS_HIT)
         |-> (rsp_hit_x_ff == '0 && rsp_hit_z_ff == '0))
      else $error("non-hit result with nonzero hit point");

   // a held result freezes the whole pipeline
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> ($stable(vld_ff) && rsp_valid_ff))
      else $error("pipeline moved while result was held");

   // a zero reduced y component always reports parallel
   assert property (@(posedge clock) disable iff (reset)
      (adv && vld_ff[mrgp_pkg::E8_STAGE] && e8_ff.d == '0)
         |=> (hc_ff[0].status == mrgp_pkg::STATUS_PARALLEL))
      else $error("zero y direction not reported as parallel");
`endif

endmodule
